// ===== rtl/dda_pkg.sv =====
// Shared widths, types and state codes for the DDA line rasterizer.
package dda_pkg;

   // Port coordinates: signed fixed point with FRAC_BITS fraction bits.
   localparam int COORD_WIDTH = 19;
   localparam int FRAC_BITS   = 8;
   // Extra fraction bits kept in the accumulators and increments.
   localparam int ACC_EXTRA   = 8;

   // Endpoint difference, its magnitude and the accumulator width.
   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int MAG_W  = COORD_WIDTH;
   localparam int ACC_W  = COORD_WIDTH + ACC_EXTRA + 1;
   // Increment magnitude stays below 2^(FRAC_BITS + ACC_EXTRA + 1).
   localparam int INC_W  = FRAC_BITS + ACC_EXTRA + 2;
   // Step counter and the largest step count.
   localparam int CNT_W  = 12;
   localparam int STEP_W = MAG_W - FRAC_BITS;

   // Divider operand widths and iteration counter.
   localparam int DVD_W   = MAG_W + ACC_EXTRA;
   localparam int DITER_W = $clog2(DVD_W);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   // Request codes carried in req_type.
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y
   } dda_state_type;

   // Command to the shared divider.
   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } div_req_type;

   // Status from the shared divider.
   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/dda_ifs.sv =====
// Valid/ready channel interfaces for the request and response items.
interface dda_req_if (input logic clock);
   import dda_pkg::*;

   logic      valid;
   logic      ready;
   logic      req_type;
   coord_type start_x;
   coord_type start_y;
   coord_type end_x;
   coord_type end_y;

   modport source (output valid, req_type, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, req_type, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dda_rsp_if (input logic clock);
   import dda_pkg::*;

   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   logic      point_valid;
   logic      last_point;

   modport source (output valid, point_x, point_y, point_valid, last_point, input ready);
   modport sink   (input valid, point_x, point_y, point_valid, last_point, output ready);
endinterface

// ===== rtl/dda_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module dda_div (
   input  logic                clock,
   input  logic                reset,
   input  dda_pkg::div_req_type div_req,
   output dda_pkg::div_rsp_type div_rsp
);
   import dda_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DITER_W-1:0] iter_ff, iter_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [DVD_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]   divisor_ff, divisor_in;
   logic [CNT_W:0]     rem_shift;
   logic [CNT_W:0]     rem_diff;
   logic               rem_ge;

   // One shift, compare and subtract per cycle.
   assign rem_shift = {rem_ff, quo_ff[DVD_W-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};
   assign rem_ge    = (rem_shift >= {1'b0, divisor_ff});

   // Load a new division or advance the current one.
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      iter_in    = iter_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         iter_in    = '0;
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = rem_ge ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], rem_ge};
         iter_in = iter_ff + 1'b1;
         if (iter_ff == DITER_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      iter_ff    <= iter_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/dda_line_rasterizer_unit.sv =====
// DDA line rasterizer: loads a line, then emits one point per step item.
//
// Channels: req (sink) carries req_type and the two endpoints; rsp (source)
// carries point_x, point_y, point_valid and last_point. An item moves on a
// rising edge where valid and ready are both high.
// A start item (req_type 0) loads the endpoints and gives no response. The
// step count is the integer part of the larger of |dx| and |dy|; the x and
// y increments come from one shared restoring divider, one quotient bit per
// cycle, x first and then y. A start item therefore keeps req.ready low
// until both the x and the y division are done, or not at all when the
// step count is zero (the line is dropped at once).
// A step item (req_type 1) is handled in the cycle it is taken: its response
// sits in an output register on the next cycle. One step item per cycle is
// sustained while the receiver takes responses. A step item without an
// active line gives a response with point_valid low and zero fields.
// When the receiver stalls, the response is held and req.ready stays low
// until it is taken. Reset is synchronous and active high; it empties the
// output register and leaves no line active.
module dda_line_rasterizer_unit (
   input logic      clock,
   input logic      reset,
   dda_req_if.sink  req,
   dda_rsp_if.source rsp
);
   import dda_pkg::*;

   dda_state_type state_ff, state_in;

   logic signed [ACC_W-1:0] cur_x_ff, cur_x_in;
   logic signed [ACC_W-1:0] cur_y_ff, cur_y_in;
   logic signed [INC_W-1:0] inc_x_ff, inc_x_in;
   logic signed [INC_W-1:0] inc_y_ff, inc_y_in;
   logic [CNT_W-1:0]        steps_left_ff, steps_left_in;
   logic                    line_active_ff, line_active_in;
   logic                    neg_x_ff, neg_x_in;
   logic                    neg_y_ff, neg_y_in;
   logic [MAG_W-1:0]        mag_y_ff, mag_y_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   coord_type               rsp_x_ff, rsp_x_in;
   coord_type               rsp_y_ff, rsp_y_in;
   logic                    rsp_pv_ff, rsp_pv_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    req_fire;
   logic                    start_fire;
   logic                    step_fire;
   logic signed [DIFF_W-1:0] dx, dy;
   logic [MAG_W-1:0]        mag_x, mag_y;
   logic [MAG_W-1:0]        mag_max;
   logic [CNT_W-1:0]        steps_calc;
   logic signed [INC_W-1:0] quo_inc;

   div_req_type div_req;
   div_rsp_type div_rsp;

   dda_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_fire   = req.valid && req.ready;
   assign start_fire = req_fire && (req.req_type == REQ_START);
   assign step_fire  = req_fire && (req.req_type == REQ_STEP);

   // Endpoint differences, magnitudes and the step count.
   assign dx      = DIFF_W'(req.end_x) - DIFF_W'(req.start_x);
   assign dy      = DIFF_W'(req.end_y) - DIFF_W'(req.start_y);
   assign mag_x   = dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
   assign mag_y   = dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
   assign mag_max = (mag_x > mag_y) ? mag_x : mag_y;
   assign steps_calc = CNT_W'(mag_max[MAG_W-1:FRAC_BITS]);

   // The quotient magnitude fits INC_W - 1 bits; restore the sign.
   assign quo_inc = INC_W'(div_rsp.quotient);

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_fire && (steps_calc != '0)) begin
               state_in = ST_DIV_X;
            end
         end
         ST_DIV_X: begin
            if (div_rsp.done) begin
               state_in = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_rsp.done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake and divider commands.
   always_comb begin
      req.ready        = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = {mag_x, {ACC_EXTRA{1'b0}}};
      div_req.divisor  = steps_calc;
      case (state_ff)
         ST_IDLE: begin
            req.ready     = !rsp_valid_ff || rsp.ready;
            div_req.start = start_fire && (steps_calc != '0);
         end
         ST_DIV_X: begin
            div_req.start    = div_rsp.done;
            div_req.dividend = {mag_y_ff, {ACC_EXTRA{1'b0}}};
            div_req.divisor  = steps_left_ff;
         end
         ST_DIV_Y: begin
            div_req.start = 1'b0;
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   // Line state: load on a start item, advance on a step item, and take the
   // increments as the divider finishes.
   always_comb begin
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      inc_x_in       = inc_x_ff;
      inc_y_in       = inc_y_ff;
      steps_left_in  = steps_left_ff;
      line_active_in = line_active_ff;
      neg_x_in       = neg_x_ff;
      neg_y_in       = neg_y_ff;
      mag_y_in       = mag_y_ff;
      if (start_fire) begin
         cur_x_in       = ACC_W'(signed'({req.start_x, {ACC_EXTRA{1'b0}}}));
         cur_y_in       = ACC_W'(signed'({req.start_y, {ACC_EXTRA{1'b0}}}));
         inc_x_in       = '0;
         inc_y_in       = '0;
         steps_left_in  = steps_calc;
         line_active_in = 1'b0;
         neg_x_in       = dx[DIFF_W-1];
         neg_y_in       = dy[DIFF_W-1];
         mag_y_in       = mag_y;
      end else if (step_fire && line_active_ff) begin
         cur_x_in      = cur_x_ff + ACC_W'(inc_x_ff);
         cur_y_in      = cur_y_ff + ACC_W'(inc_y_ff);
         steps_left_in = steps_left_ff - 1'b1;
         if (steps_left_ff == CNT_W'(1)) begin
            line_active_in = 1'b0;
         end
      end
      if ((state_ff == ST_DIV_X) && div_rsp.done) begin
         inc_x_in = neg_x_ff ? -quo_inc : quo_inc;
      end
      if ((state_ff == ST_DIV_Y) && div_rsp.done) begin
         inc_y_in       = neg_y_ff ? -quo_inc : quo_inc;
         line_active_in = 1'b1;
      end
   end

   // Output register: filled by a step item, emptied when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_pv_in    = rsp_pv_ff;
      rsp_last_in  = rsp_last_ff;
      if (step_fire) begin
         rsp_valid_in = 1'b1;
         if (line_active_ff) begin
            rsp_x_in    = cur_x_ff[ACC_EXTRA +: COORD_WIDTH];
            rsp_y_in    = cur_y_ff[ACC_EXTRA +: COORD_WIDTH];
            rsp_pv_in   = 1'b1;
            rsp_last_in = (steps_left_ff == CNT_W'(1));
         end else begin
            rsp_x_in    = '0;
            rsp_y_in    = '0;
            rsp_pv_in   = 1'b0;
            rsp_last_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         steps_left_ff  <= '0;
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         steps_left_ff  <= steps_left_in;
         line_active_ff <= line_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      inc_x_ff    <= inc_x_in;
      inc_y_ff    <= inc_y_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      mag_y_ff    <= mag_y_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_pv_ff   <= rsp_pv_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.point_x     = rsp_x_ff;
   assign rsp.point_y     = rsp_y_ff;
   assign rsp.point_valid = rsp_pv_ff;
   assign rsp.last_point  = rsp_last_ff;

   // An active line always has points left to emit.
   a_active_has_steps: assert property (@(posedge clock) disable iff (reset)
      line_active_ff |-> (steps_left_ff != '0))
      else $error("active line with no steps left");

   // The divider only finishes while the sequencer waits for it.
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> ((state_ff == ST_DIV_X) || (state_ff == ST_DIV_Y)))
      else $error("divider finished outside a division state");

   // The second division completes the load and activates the line.
   a_load_activates: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV_Y) && div_rsp.done) |=> (line_active_ff && (state_ff == ST_IDLE)))
      else $error("line not active after increments were loaded");

endmodule

// ===== verif/dda_line_rasterizer_unit_test.sv =====
// Self-checking testbench for the DDA line rasterizer unit.
`timescale 1ns / 100ps

module dda_line_rasterizer_unit_test;
   import dda_pkg::*;

   localparam int     CLOCK_PERIOD    = 10;
   localparam int     RESET_CYCLES    = 12;
   localparam int     RSP_HOLD_CYCLES = 300;
   localparam int     DRAIN_CYCLES    = 2 * (DVD_W + 1) + 40;
   localparam int     MAX_REPORTS     = 10;
   localparam int     MAX_LINE_POINTS = 40;
   localparam longint TIMEOUT_NS      = 3_000_000;
   localparam longint COORD_HI        = (longint'(1) << (COORD_WIDTH - 1)) - 1;
   localparam longint COORD_LO        = -(longint'(1) << (COORD_WIDTH - 1));
   localparam longint STEP_COUNT_MAX  = (longint'(1) << CNT_W) - 1;

   // One request item as offered on the input channel.
   typedef struct {
      logic      req_type;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } line_req_type;

   // One emitted point as seen on the result channel.
   typedef struct {
      coord_type x;
      coord_type y;
      logic      valid;
      logic      last;
   } line_point_type;

   logic clock = 1'b0;
   logic reset;

   dda_req_if req (clock);
   dda_rsp_if rsp (clock);

   dda_line_rasterizer_unit i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Line state of the predictor, at the widths of the block.
   logic signed [ACC_W-1:0] line_cur_x;
   logic signed [ACC_W-1:0] line_cur_y;
   logic signed [INC_W-1:0] line_inc_x;
   logic signed [INC_W-1:0] line_inc_y;
   logic [CNT_W-1:0]        line_steps_left;
   logic                    line_active;

   line_point_type expected_points[$];

   int send_idle_pct;
   int recv_idle_pct;
   int mismatch_count;
   int items_sent;
   int lines_started;
   int points_checked;
   int idle_points_checked;

   // Long receiver stall: the test flips the request bit, the receiver counts.
   logic hold_toggle;
   logic hold_toggle_seen;
   int   hold_left;

   // Apply one accepted item to the predicted line state.
   function automatic void rasterize_request(line_req_type rq);
      longint         sx;
      longint         sy;
      longint         dx;
      longint         dy;
      longint         ax;
      longint         ay;
      longint         steps;
      line_point_type pt;
      if (rq.req_type == REQ_START) begin
         sx = rq.start_x;
         sy = rq.start_y;
         dx = longint'(rq.end_x) - sx;
         dy = longint'(rq.end_y) - sy;
         ax = (dx < 0) ? -dx : dx;
         ay = (dy < 0) ? -dy : dy;
         steps = ((ax > ay) ? ax : ay) >>> FRAC_BITS;
         if (steps > STEP_COUNT_MAX) begin
            steps = STEP_COUNT_MAX;
         end
         line_cur_x = ACC_W'(sx <<< ACC_EXTRA);
         line_cur_y = ACC_W'(sy <<< ACC_EXTRA);
         if (steps == 0) begin
            line_inc_x      = '0;
            line_inc_y      = '0;
            line_steps_left = '0;
            line_active     = 1'b0;
         end else begin
            line_inc_x      = INC_W'((dx <<< ACC_EXTRA) / steps);
            line_inc_y      = INC_W'((dy <<< ACC_EXTRA) / steps);
            line_steps_left = CNT_W'(steps);
            line_active     = 1'b1;
         end
         lines_started++;
         return;
      end
      if (!line_active) begin
         pt.x     = '0;
         pt.y     = '0;
         pt.valid = 1'b0;
         pt.last  = 1'b0;
         expected_points.push_back(pt);
         return;
      end
      // Dropping the extra fraction bits rounds toward minus infinity.
      pt.x     = line_cur_x[ACC_EXTRA +: COORD_WIDTH];
      pt.y     = line_cur_y[ACC_EXTRA +: COORD_WIDTH];
      pt.valid = 1'b1;
      pt.last  = (line_steps_left == 1);
      expected_points.push_back(pt);
      line_cur_x      = line_cur_x + line_inc_x;
      line_cur_y      = line_cur_y + line_inc_y;
      line_steps_left = line_steps_left - 1'b1;
      if (line_steps_left == 0) begin
         line_active = 1'b0;
      end
   endfunction

   function automatic void report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endfunction

   // Compare one accepted point with the oldest expected point.
   function automatic void check_point();
      line_point_type got;
      line_point_type want;
      got.x     = rsp.point_x;
      got.y     = rsp.point_y;
      got.valid = rsp.point_valid;
      got.last  = rsp.last_point;
      if (expected_points.size() == 0) begin
         report_mismatch($sformatf("unexpected point x=%0d y=%0d valid=%0b last=%0b",
                                   got.x, got.y, got.valid, got.last));
         return;
      end
      want = expected_points.pop_front();
      points_checked++;
      if (!want.valid) begin
         idle_points_checked++;
      end
      if (got.x !== want.x || got.y !== want.y || got.valid !== want.valid ||
          got.last !== want.last) begin
         report_mismatch($sformatf(
            "point %0d: expected x=%0d y=%0d valid=%0b last=%0b, got x=%0d y=%0d valid=%0b last=%0b",
            points_checked, want.x, want.y, want.valid, want.last,
            got.x, got.y, got.valid, got.last));
      end
   endfunction

   // Result side: check each accepted point, then pick the next ready value.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready        <= 1'b0;
         hold_toggle_seen = hold_toggle;
         hold_left        = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            check_point();
         end
         if (hold_toggle != hold_toggle_seen) begin
            hold_toggle_seen = hold_toggle;
            hold_left        = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic coord_type rand_coord();
      return coord_type'($urandom);
   endfunction

   function automatic line_req_type step_req();
      line_req_type rq;
      rq.req_type = REQ_STEP;
      rq.start_x  = rand_coord();
      rq.start_y  = rand_coord();
      rq.end_x    = rand_coord();
      rq.end_y    = rand_coord();
      return rq;
   endfunction

   function automatic line_req_type line_req(coord_type sx, coord_type sy, coord_type ex,
                                             coord_type ey);
      line_req_type rq;
      rq.req_type = REQ_START;
      rq.start_x  = sx;
      rq.start_y  = sy;
      rq.end_x    = ex;
      rq.end_y    = ey;
      return rq;
   endfunction

   // Signed span in port units: mostly short lines, some below one unit.
   function automatic longint rand_span();
      longint mag;
      int     pick;
      pick = $urandom_range(99);
      if (pick < 5) begin
         mag = 0;
      end else if (pick < 15) begin
         mag = $urandom_range(0, (1 << FRAC_BITS) - 1);
      end else begin
         mag = $urandom_range(0, 12 * (1 << FRAC_BITS) + (1 << FRAC_BITS) - 1);
      end
      return ($urandom_range(1) != 0) ? -mag : mag;
   endfunction

   // Move the end point by the span, reflecting it back if it leaves the range.
   function automatic coord_type offset_coord(coord_type base, longint span);
      longint p;
      p = longint'(base) + span;
      if (p > COORD_HI || p < COORD_LO) begin
         p = longint'(base) - span;
      end
      return coord_type'(p);
   endfunction

   function automatic line_req_type random_line();
      coord_type sx;
      coord_type sy;
      sx = rand_coord();
      sy = rand_coord();
      if ($urandom_range(99) < 6) begin
         return line_req(sx, sy, rand_coord(), rand_coord());
      end
      return line_req(sx, sy, offset_coord(sx, rand_span()), offset_coord(sy, rand_span()));
   endfunction

   // Offer one item, with random gaps before it, and wait until it is taken.
   task automatic send_item(input line_req_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid    <= 1'b1;
      req.req_type <= rq.req_type;
      req.start_x  <= rq.start_x;
      req.start_y  <= rq.start_y;
      req.end_x    <= rq.end_x;
      req.end_y    <= rq.end_y;
      @(posedge clock);
      while (!req.ready) begin
         @(posedge clock);
      end
      items_sent++;
      rasterize_request(rq);
   endtask

   // Stop offering items until every expected point has come back.
   task automatic wait_for_points();
      req.valid <= 1'b0;
      @(posedge clock);
      while (expected_points.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Step items right after reset find no line.
   task automatic test_steps_without_line();
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      repeat (2) send_item(step_req());
      wait_for_points();
   endtask

   // Extreme endpoints, restart mid-line, short lines and running past the end.
   task automatic test_directed_lines();
      send_item(line_req(coord_type'(COORD_LO), coord_type'(COORD_LO),
                         coord_type'(COORD_HI), coord_type'(COORD_HI)));
      repeat (3) send_item(step_req());
      send_item(line_req(coord_type'(COORD_HI), coord_type'(COORD_LO),
                         coord_type'(COORD_LO), coord_type'(COORD_HI)));
      repeat (2) send_item(step_req());
      // Start equals end: the line ends at once.
      send_item(line_req(coord_type'(1234), coord_type'(-77),
                         coord_type'(1234), coord_type'(-77)));
      send_item(step_req());
      // Just under one unit long: still no points.
      send_item(line_req(coord_type'(-100), coord_type'(40),
                         coord_type'(155), coord_type'(295)));
      send_item(step_req());
      // Exactly one unit from a negative fraction: one point, then none.
      send_item(line_req(coord_type'(-5), coord_type'(-3),
                         coord_type'(251), coord_type'(-3)));
      repeat (2) send_item(step_req());
      // Steep line heading down with a shallow x slope.
      send_item(line_req(coord_type'(-1), coord_type'(0),
                         coord_type'(299), coord_type'(-1000)));
      repeat (4) send_item(step_req());
      wait_for_points();
   endtask

   // Mostly whole lines with random content, plus stray steps and cut-off lines.
   task automatic test_random_lines(input int send_pct, input int recv_pct,
                                    input int n_items);
      int sent;
      int length;
      int n_steps;
      int pick;
      send_idle_pct = send_pct;
      recv_idle_pct <= recv_pct;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 8) begin
            send_item(step_req());
            sent++;
         end else begin
            send_item(random_line());
            sent++;
            length = int'(line_steps_left);
            if (length > MAX_LINE_POINTS) begin
               length = $urandom_range(1, MAX_LINE_POINTS);
            end
            pick = $urandom_range(99);
            if (pick < 15 && length > 0) begin
               n_steps = $urandom_range(0, length - 1);
            end else if (pick < 30) begin
               n_steps = length + $urandom_range(1, 3);
            end else begin
               n_steps = length;
            end
            repeat (n_steps) begin
               send_item(step_req());
               sent++;
            end
         end
      end
      wait_for_points();
   endtask

   // The receiver stalls for a long stretch while step items keep coming.
   task automatic test_receiver_hold();
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      send_item(line_req(coord_type'(0), coord_type'(0),
                         coord_type'(30 * 256 + 77), coord_type'(-12 * 256)));
      hold_toggle <= ~hold_toggle;
      repeat (25) send_item(step_req());
      wait_for_points();
   endtask

   initial begin
      reset        <= 1'b1;
      req.valid    <= 1'b0;
      req.req_type <= REQ_STEP;
      req.start_x  <= '0;
      req.start_y  <= '0;
      req.end_x    <= '0;
      req.end_y    <= '0;
      hold_toggle  <= 1'b0;
      recv_idle_pct       <= 0;
      send_idle_pct       = 0;
      mismatch_count      = 0;
      items_sent          = 0;
      lines_started       = 0;
      points_checked      = 0;
      idle_points_checked = 0;
      line_cur_x      = '0;
      line_cur_y      = '0;
      line_inc_x      = '0;
      line_inc_y      = '0;
      line_steps_left = '0;
      line_active     = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_steps_without_line();
      test_directed_lines();
      test_random_lines(24, 69, 120);
      test_random_lines(69, 24, 120);
      test_random_lines(0, 0, 120);
      test_receiver_hold();

      wait_for_points();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_points.size() != 0) begin
         report_mismatch($sformatf("%0d expected points never arrived",
                                   expected_points.size()));
      end
      $display("Run covered %0d items over %0d lines, %0d points checked (%0d with no line).",
               items_sent, lines_started, points_checked, idle_points_checked);
      $display("Both channels idled at random, and the receiver held off for %0d cycles once.",
               RSP_HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("ERROR: timeout with %0d points still expected", expected_points.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
